// File: design/klc_pkg.sv
// Package for the keypad code lock controller.
// Holds item structs, event and status codes, mode enums and reset constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package klc_pkg;

	localparam int MAX_DIGITS_DEF = 9;
	localparam int INIT_CODE_LEN  = 6;

	localparam logic [7:0] SHORT_WAIT_RST = 8'd30;
	localparam logic [7:0] LONG_WAIT_RST  = 8'd60;
	localparam logic [3:0] NEW_LEN_RST    = 4'd6;

	typedef struct packed {
		logic [3:0] req_type;
		logic [3:0] digit;
	} in_item_t;

	typedef struct packed {
		logic [1:0] motor_cmd;
		logic [3:0] status_code;
		logic       phone_pulse;
		logic [1:0] log_pulse;
		logic       waiting;
	} out_item_t;

	typedef enum logic [1:0] {
		CFG_SHORT_WAIT = 2'd0,
		CFG_LONG_WAIT  = 2'd1,
		CFG_NEW_LEN    = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		REQ_DIGIT    = 4'd0,
		REQ_STAR     = 4'd1,
		REQ_HASH     = 4'd2,
		REQ_KEY_A    = 4'd3,
		REQ_KEY_B    = 4'd4,
		REQ_KEY_C    = 4'd5,
		REQ_KEY_D    = 4'd6,
		REQ_PH_RESET = 4'd7,
		REQ_PH_ANS   = 4'd8,
		REQ_IDLE     = 4'd9,
		REQ_TICK     = 4'd10
	} req_t;

	typedef enum logic [3:0] {
		ST_NONE     = 4'd0,
		ST_DIGIT    = 4'd1,
		ST_GRANTED  = 4'd2,
		ST_WRONG    = 4'd3,
		ST_WAIT     = 4'd4,
		ST_HARD     = 4'd5,
		ST_VERIFIED = 4'd6,
		ST_STORED   = 4'd7,
		ST_CLEARED  = 4'd8,
		ST_CHANGE   = 4'd9,
		ST_RESET    = 4'd10,
		ST_PHONE    = 4'd11,
		ST_UNLOCKED = 4'd12,
		ST_ANSWER   = 4'd13,
		ST_LOCKED   = 4'd14,
		ST_IGNORED  = 4'd15
	} status_t;

	typedef enum logic [1:0] {
		MOTOR_NONE   = 2'd0,
		MOTOR_LOCK   = 2'd1,
		MOTOR_UNLOCK = 2'd2
	} motor_t;

	typedef enum logic [1:0] {
		LOG_NONE     = 2'd0,
		LOG_PRESENCE = 2'd1,
		LOG_CODE     = 2'd2
	} log_t;

	typedef enum logic [1:0] {
		LOCK_NONE   = 2'd0,
		LOCK_HARD   = 2'd1,
		LOCK_ANSWER = 2'd2
	} lock_mode_t;

	typedef enum logic [1:0] {
		PHONE_IDLE   = 2'd0,
		PHONE_RESET  = 2'd1,
		PHONE_ANSWER = 2'd2
	} phone_mode_t;

	typedef enum logic [1:0] {
		CHG_NONE   = 2'd0,
		CHG_ACTIVE = 2'd1,
		CHG_FORCED = 2'd2
	} change_mode_t;

	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_IGNORED,
		ACT_TICK,
		ACT_DIGIT_ENTRY,
		ACT_DIGIT_BOTH,
		ACT_DIGIT_NEW,
		ACT_GRANT_CODE,
		ACT_WRONG,
		ACT_WAIT_SHORT,
		ACT_WAIT_LONG,
		ACT_HARD,
		ACT_VERIFIED,
		ACT_VERIFY_FAIL,
		ACT_STORED_BOTH,
		ACT_STORED_NEW,
		ACT_STAR_LOCK,
		ACT_CLEAR_ENTRY,
		ACT_CLEAR_NEW,
		ACT_CHANGE,
		ACT_RESET_ASK,
		ACT_ANSWER_ASK,
		ACT_PHONE_RESET,
		ACT_PHONE_ANSWER,
		ACT_UNLOCKED,
		ACT_ANSWERED,
		ACT_PRESENCE_GRANT,
		ACT_PRESENCE_LOCK
	} action_t;

	typedef struct packed {
		logic push_entry;
		logic push_new;
		logic commit;
	} store_cmd_t;

	function automatic logic [3:0] init_digit(input int i);
		logic [3:0] d;
		d = (i < INIT_CODE_LEN) ? 4'(i + 1) : 4'd0;
		return d;
	endfunction

endpackage

`default_nettype wire

// File: design/klc_digit_store.sv
// Digit storage: stored code, entry digits and new-code digits.
// Parallel compare of the entry (with the incoming digit) against the stored code.
// Depends on klc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module klc_digit_store
	import klc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int LEN_W = $clog2(MAX_DIGITS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire store_cmd_t       cmd,
	input  wire logic [3:0]       digit,
	input  wire logic [LEN_W-1:0] entry_pos,
	input  wire logic [LEN_W-1:0] new_pos,
	input  wire logic [LEN_W-1:0] stored_len,
	output logic                  match
);

	logic [3:0] stored_q [MAX_DIGITS];
	logic [3:0] entry_q  [MAX_DIGITS];
	logic [3:0] new_q    [MAX_DIGITS];
	logic [3:0] entry_view [MAX_DIGITS];
	logic [3:0] new_view   [MAX_DIGITS];

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			entry_view[i] = (LEN_W'(i) == entry_pos) ? digit : entry_q[i];
			new_view[i]   = (LEN_W'(i) == new_pos) ? digit : new_q[i];
		end
	end

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (LEN_W'(i) < stored_len && entry_view[i] != stored_q[i]) begin
				match = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (cmd.push_entry && LEN_W'(i) == entry_pos) begin
				entry_q[i] <= digit;
			end
			if (cmd.push_new && LEN_W'(i) == new_pos) begin
				new_q[i] <= digit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				stored_q[i] <= init_digit(i);
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				stored_q[i] <= new_view[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/klc_ctrl.sv
// Lock control: modes, attempt count, lengths and wait timer.
// Decodes one item into an action, updates state and forms the result item.
// Depends on klc_pkg; works with klc_digit_store.
`timescale 1ns / 1ps
`default_nettype none

module klc_ctrl
	import klc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int LEN_W = $clog2(MAX_DIGITS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire in_item_t         item,
	input  wire logic [7:0]       short_wait,
	input  wire logic [7:0]       long_wait,
	input  wire logic [3:0]       new_code_len,
	input  wire logic             match,
	output store_cmd_t            store_cmd,
	output logic [LEN_W-1:0]      entry_pos,
	output logic [LEN_W-1:0]      new_pos,
	output logic [LEN_W-1:0]      stored_len,
	output out_item_t             result
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DIGITS);

	logic [LEN_W-1:0] entry_len_q, entry_len_d;
	logic [LEN_W-1:0] new_len_q, new_len_d;
	logic [LEN_W-1:0] stored_len_q, stored_len_d;
	logic [2:0]       attempt_q, attempt_d;
	logic             door_q, door_d;
	logic             presence_q, presence_d;
	logic             reset_ask_q, reset_ask_d;
	logic             answer_ask_q, answer_ask_d;
	logic             verified_q, verified_d;
	logic [7:0]       wait_q, wait_d;
	lock_mode_t       lock_q, lock_d;
	phone_mode_t      phone_q, phone_d;
	change_mode_t     chg_q, chg_d;

	logic [LEN_W-1:0] entry_pushed;
	logic [LEN_W-1:0] new_pushed;
	logic             attempt_ok;
	logic             entry_full_len;
	logic             new_done;
	action_t          act;
	store_cmd_t       cmd;

	assign entry_pushed   = (entry_len_q < LEN_MAX) ? entry_len_q + 1'b1 : entry_len_q;
	assign new_pushed     = (new_len_q < LEN_MAX) ? new_len_q + 1'b1 : new_len_q;
	assign attempt_ok     = (attempt_q >= 3'd1) && (attempt_q <= 3'd5);
	assign entry_full_len = (entry_pushed == stored_len_q);
	assign new_done       = (4'(new_pushed) == new_code_len);

	assign entry_pos  = entry_len_q;
	assign new_pos    = new_len_q;
	assign stored_len = stored_len_q;

	always_comb begin
		act = ACT_IGNORED;
		if (req_t'(item.req_type) == REQ_TICK) begin
			act = (wait_q != 8'd0) ? ACT_TICK : ACT_NONE;
		end else if (wait_q != 8'd0) begin
			act = ACT_IGNORED;
		end else begin
			unique case (req_t'(item.req_type))
				REQ_DIGIT: begin
					priority if (lock_q != LOCK_NONE) begin
						act = ACT_IGNORED;
					end else if (!door_q && chg_q == CHG_NONE) begin
						priority if (!attempt_ok || !entry_full_len) begin
							act = ACT_DIGIT_ENTRY;
						end else if (match) begin
							act = ACT_GRANT_CODE;
						end else if (attempt_q == 3'd3) begin
							act = ACT_WAIT_SHORT;
						end else if (attempt_q == 3'd4) begin
							act = ACT_WAIT_LONG;
						end else if (attempt_q == 3'd5) begin
							act = ACT_HARD;
						end else begin
							act = ACT_WRONG;
						end
					end else if (chg_q == CHG_ACTIVE) begin
						priority if (!verified_q) begin
							if (!entry_full_len) begin
								act = ACT_DIGIT_ENTRY;
							end else begin
								act = match ? ACT_VERIFIED : ACT_VERIFY_FAIL;
							end
						end else begin
							act = new_done ? ACT_STORED_BOTH : ACT_DIGIT_BOTH;
						end
					end else if (chg_q == CHG_FORCED) begin
						act = new_done ? ACT_STORED_NEW : ACT_DIGIT_NEW;
					end else begin
						act = ACT_IGNORED;
					end
				end
				REQ_STAR: begin
					if (lock_q == LOCK_NONE && door_q) begin
						act = ACT_STAR_LOCK;
					end
				end
				REQ_HASH: begin
					priority if (!door_q && !verified_q && chg_q == CHG_NONE
							&& lock_q == LOCK_NONE) begin
						act = ACT_CLEAR_ENTRY;
					end else if (chg_q == CHG_ACTIVE && !verified_q) begin
						act = ACT_CLEAR_ENTRY;
					end else if (chg_q == CHG_ACTIVE || chg_q == CHG_FORCED) begin
						act = ACT_CLEAR_NEW;
					end else begin
						act = ACT_IGNORED;
					end
				end
				REQ_KEY_A: begin
					if (lock_q == LOCK_NONE) begin
						act = ACT_CHANGE;
					end
				end
				REQ_KEY_B: begin
					if (lock_q == LOCK_HARD) begin
						act = ACT_RESET_ASK;
					end
				end
				REQ_KEY_C: begin
					priority if (lock_q == LOCK_NONE && !answer_ask_q) begin
						act = ACT_ANSWER_ASK;
					end else if (lock_q == LOCK_HARD && reset_ask_q) begin
						act = ACT_PHONE_RESET;
					end else begin
						act = ACT_IGNORED;
					end
				end
				REQ_KEY_D: begin
					if (answer_ask_q) begin
						act = ACT_PHONE_ANSWER;
					end
				end
				REQ_PH_RESET: begin
					if (lock_q == LOCK_HARD && reset_ask_q && phone_q == PHONE_RESET) begin
						act = ACT_UNLOCKED;
					end
				end
				REQ_PH_ANS: begin
					if (lock_q == LOCK_ANSWER && answer_ask_q && phone_q == PHONE_ANSWER) begin
						act = ACT_ANSWERED;
					end
				end
				REQ_IDLE: begin
					priority if (!presence_q && !door_q) begin
						act = ACT_PRESENCE_GRANT;
					end else if (door_q) begin
						act = ACT_PRESENCE_LOCK;
					end else begin
						act = ACT_IGNORED;
					end
				end
				default: act = ACT_IGNORED;
			endcase
		end
	end

	always_comb begin
		entry_len_d  = entry_len_q;
		new_len_d    = new_len_q;
		stored_len_d = stored_len_q;
		attempt_d    = attempt_q;
		door_d       = door_q;
		presence_d   = presence_q;
		reset_ask_d  = reset_ask_q;
		answer_ask_d = answer_ask_q;
		verified_d   = verified_q;
		wait_d       = wait_q;
		lock_d       = lock_q;
		phone_d      = phone_q;
		chg_d        = chg_q;
		cmd          = '0;
		unique case (act)
			ACT_TICK: wait_d = wait_q - 8'd1;
			ACT_DIGIT_ENTRY: begin
				entry_len_d    = entry_pushed;
				cmd.push_entry = 1'b1;
			end
			ACT_DIGIT_BOTH: begin
				entry_len_d    = entry_pushed;
				new_len_d      = new_pushed;
				cmd.push_entry = 1'b1;
				cmd.push_new   = 1'b1;
			end
			ACT_DIGIT_NEW: begin
				new_len_d    = new_pushed;
				cmd.push_new = 1'b1;
			end
			ACT_GRANT_CODE: begin
				entry_len_d    = '0;
				door_d         = 1'b1;
				presence_d     = 1'b0;
				attempt_d      = 3'd1;
				cmd.push_entry = 1'b1;
			end
			ACT_WRONG: begin
				entry_len_d    = '0;
				attempt_d      = attempt_q + 3'd1;
				cmd.push_entry = 1'b1;
			end
			ACT_WAIT_SHORT: begin
				entry_len_d    = '0;
				attempt_d      = attempt_q + 3'd1;
				wait_d         = short_wait;
				cmd.push_entry = 1'b1;
			end
			ACT_WAIT_LONG: begin
				entry_len_d    = '0;
				attempt_d      = attempt_q + 3'd1;
				wait_d         = long_wait;
				cmd.push_entry = 1'b1;
			end
			ACT_HARD: begin
				entry_len_d    = '0;
				attempt_d      = attempt_q + 3'd1;
				lock_d         = LOCK_HARD;
				cmd.push_entry = 1'b1;
			end
			ACT_VERIFIED: begin
				entry_len_d    = '0;
				verified_d     = 1'b1;
				cmd.push_entry = 1'b1;
			end
			ACT_VERIFY_FAIL: begin
				entry_len_d    = '0;
				chg_d          = CHG_NONE;
				cmd.push_entry = 1'b1;
			end
			ACT_STORED_BOTH, ACT_STORED_NEW: begin
				stored_len_d   = new_pushed;
				new_len_d      = '0;
				entry_len_d    = '0;
				verified_d     = 1'b0;
				chg_d          = CHG_NONE;
				cmd.push_entry = (act == ACT_STORED_BOTH);
				cmd.push_new   = 1'b1;
				cmd.commit     = 1'b1;
			end
			ACT_STAR_LOCK: begin
				door_d     = 1'b0;
				presence_d = 1'b0;
			end
			ACT_CLEAR_ENTRY: entry_len_d = '0;
			ACT_CLEAR_NEW:   new_len_d = '0;
			ACT_CHANGE: begin
				entry_len_d = '0;
				new_len_d   = '0;
				chg_d       = CHG_ACTIVE;
			end
			ACT_RESET_ASK:   reset_ask_d = 1'b1;
			ACT_ANSWER_ASK:  answer_ask_d = 1'b1;
			ACT_PHONE_RESET: phone_d = PHONE_RESET;
			ACT_PHONE_ANSWER: begin
				lock_d  = LOCK_ANSWER;
				phone_d = PHONE_ANSWER;
			end
			ACT_UNLOCKED: begin
				lock_d      = LOCK_NONE;
				reset_ask_d = 1'b0;
				phone_d     = PHONE_IDLE;
				attempt_d   = 3'd1;
				chg_d       = CHG_FORCED;
			end
			ACT_ANSWERED: begin
				answer_ask_d = 1'b0;
				lock_d       = LOCK_NONE;
				phone_d      = PHONE_IDLE;
			end
			ACT_PRESENCE_GRANT: begin
				presence_d   = 1'b1;
				door_d       = 1'b1;
				attempt_d    = 3'd1;
				lock_d       = LOCK_NONE;
				reset_ask_d  = 1'b0;
				phone_d      = PHONE_IDLE;
				answer_ask_d = 1'b0;
			end
			ACT_PRESENCE_LOCK: begin
				presence_d = 1'b0;
				door_d     = 1'b0;
				attempt_d  = 3'd1;
				phone_d    = PHONE_IDLE;
			end
			default: ;
		endcase
	end

	assign store_cmd = fire ? cmd : '0;

	always_comb begin
		result             = '0;
		result.status_code = ST_IGNORED;
		result.waiting     = (wait_d != 8'd0);
		unique case (act)
			ACT_NONE: result.status_code = ST_NONE;
			ACT_TICK, ACT_WAIT_SHORT, ACT_WAIT_LONG: result.status_code = ST_WAIT;
			ACT_DIGIT_ENTRY, ACT_DIGIT_BOTH, ACT_DIGIT_NEW: result.status_code = ST_DIGIT;
			ACT_GRANT_CODE: begin
				result.status_code = ST_GRANTED;
				result.motor_cmd   = MOTOR_UNLOCK;
				result.log_pulse   = LOG_CODE;
			end
			ACT_WRONG, ACT_VERIFY_FAIL: result.status_code = ST_WRONG;
			ACT_HARD:     result.status_code = ST_HARD;
			ACT_VERIFIED: result.status_code = ST_VERIFIED;
			ACT_STORED_BOTH, ACT_STORED_NEW: result.status_code = ST_STORED;
			ACT_STAR_LOCK, ACT_PRESENCE_LOCK: begin
				result.status_code = ST_LOCKED;
				result.motor_cmd   = MOTOR_LOCK;
			end
			ACT_CLEAR_ENTRY, ACT_CLEAR_NEW: result.status_code = ST_CLEARED;
			ACT_CHANGE:     result.status_code = ST_CHANGE;
			ACT_RESET_ASK:  result.status_code = ST_RESET;
			ACT_ANSWER_ASK: result.status_code = ST_PHONE;
			ACT_PHONE_RESET, ACT_PHONE_ANSWER: begin
				result.status_code = ST_PHONE;
				result.phone_pulse = 1'b1;
			end
			ACT_UNLOCKED: result.status_code = ST_UNLOCKED;
			ACT_ANSWERED: result.status_code = ST_ANSWER;
			ACT_PRESENCE_GRANT: begin
				result.status_code = ST_GRANTED;
				result.motor_cmd   = MOTOR_UNLOCK;
				result.log_pulse   = LOG_PRESENCE;
			end
			default: result.status_code = ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_len_q  <= '0;
			new_len_q    <= '0;
			stored_len_q <= LEN_W'(INIT_CODE_LEN);
			attempt_q    <= 3'd1;
			door_q       <= 1'b0;
			presence_q   <= 1'b0;
			reset_ask_q  <= 1'b0;
			answer_ask_q <= 1'b0;
			verified_q   <= 1'b0;
			wait_q       <= 8'd0;
			lock_q       <= LOCK_NONE;
			phone_q      <= PHONE_IDLE;
			chg_q        <= CHG_NONE;
		end else if (fire) begin
			entry_len_q  <= entry_len_d;
			new_len_q    <= new_len_d;
			stored_len_q <= stored_len_d;
			attempt_q    <= attempt_d;
			door_q       <= door_d;
			presence_q   <= presence_d;
			reset_ask_q  <= reset_ask_d;
			answer_ask_q <= answer_ask_d;
			verified_q   <= verified_d;
			wait_q       <= wait_d;
			lock_q       <= lock_d;
			phone_q      <= phone_d;
			chg_q        <= chg_d;
		end
	end

endmodule

`default_nettype wire

// File: design/keypad_code_lock_controller.sv
// Keypad code lock controller, top level.
// Input register, configuration registers, result register; uses klc_ctrl,
// klc_digit_store and klc_pkg.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one event item: a key, a
//   phone confirmation, a presence-idle event or a one-second tick.
//   res channel (res_valid, res_stall, res) returns exactly one result item per
//   event: motor command, status code, phone and log pulses, waiting flag.
//   An item accepted at a clock edge sits in the input register; its result
//   is loaded into the result register once that register is empty or being
//   drained. One item per cycle is sustained while res_stall is low: the
//   decode, the parallel code compare and the state update all fit between
//   the input register and the result register.
//   If res_stall is held, the result register holds its item and the input
//   register can still take one more item; req_stall rises only when both are
//   full. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge; the user must make them while no item is in flight (not enforced).
//   Reset clears all control state, restores the code 1 2 3 4 5 6 and the
//   default wait times and new-code length; no items are in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_controller
	import klc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire in_item_t   req,
	output logic            res_valid,
	input  wire logic       res_stall,
	output out_item_t       res,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int LEN_W = $clog2(MAX_DIGITS + 1);

	in_item_t         req_s1;
	logic             valid_s1;
	out_item_t        res_s2;
	logic             valid_s2;
	logic [7:0]       short_wait_q;
	logic [7:0]       long_wait_q;
	logic [3:0]       new_len_cfg_q;
	logic             fire;
	logic             accept;
	logic             match;
	store_cmd_t       store_cmd;
	logic [LEN_W-1:0] entry_pos;
	logic [LEN_W-1:0] new_pos;
	logic [LEN_W-1:0] stored_len;
	out_item_t        result;

	assign fire      = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !(!valid_s2 || !res_stall);
	assign accept    = req_valid && !req_stall;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (fire) begin
			res_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_wait_q  <= SHORT_WAIT_RST;
			long_wait_q   <= LONG_WAIT_RST;
			new_len_cfg_q <= NEW_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SHORT_WAIT: short_wait_q <= cfg_data;
				CFG_LONG_WAIT:  long_wait_q <= cfg_data;
				CFG_NEW_LEN:    new_len_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	klc_ctrl #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (req_s1),
		.short_wait   (short_wait_q),
		.long_wait    (long_wait_q),
		.new_code_len (new_len_cfg_q),
		.match        (match),
		.store_cmd    (store_cmd),
		.entry_pos    (entry_pos),
		.new_pos      (new_pos),
		.stored_len   (stored_len),
		.result       (result)
	);

	klc_digit_store #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (store_cmd),
		.digit      (req_s1.digit),
		.entry_pos  (entry_pos),
		.new_pos    (new_pos),
		.stored_len (stored_len),
		.match      (match)
	);

endmodule

`default_nettype wire

// File: tb/sv/keypad_code_lock_controller_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypad_code_lock_controller: directed and random key events
// over the valid/stall channels, each result checked against a built-in model of the lock.
// Depends on klc_pkg and the controller RTL.

module keypad_code_lock_controller_test;
	import klc_pkg::*;

	localparam int DIGITS = MAX_DIGITS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX = 10;
	localparam logic [3:0] REQ_SPARE_LO = 4'd11;
	localparam logic [3:0] REQ_SPARE_HI = 4'd15;

	class code_lock_mirror;
		logic [7:0] short_wait, long_wait;
		logic [3:0] fresh_len_cfg;
		logic [3:0] code_q [DIGITS];
		logic [3:0] entry_q [DIGITS];
		logic [3:0] fresh_q [DIGITS];
		logic [3:0] code_len, entry_len, fresh_len;
		logic [2:0] attempt;
		bit door_open, presence_served, reset_asked, answer_asked, verified;
		lock_mode_t lock_mode;
		phone_mode_t phone_mode;
		change_mode_t change_mode;
		logic [7:0] wait_left;
		out_item_t r;
		out_item_t due [$];
		int bad_results;

		function new();
			short_wait = SHORT_WAIT_RST;
			long_wait = LONG_WAIT_RST;
			fresh_len_cfg = NEW_LEN_RST;
			for (int i = 0; i < DIGITS; i++) begin
				code_q[i] = (i < INIT_CODE_LEN) ? 4'(i + 1) : 4'd0;
				entry_q[i] = 4'd0;
				fresh_q[i] = 4'd0;
			end
			code_len = 4'(INIT_CODE_LEN);
			entry_len = 4'd0;
			fresh_len = 4'd0;
			attempt = 3'd1;
			door_open = 0;
			presence_served = 0;
			reset_asked = 0;
			answer_asked = 0;
			verified = 0;
			lock_mode = LOCK_NONE;
			phone_mode = PHONE_IDLE;
			change_mode = CHG_NONE;
			wait_left = 8'd0;
			bad_results = 0;
		endfunction

		function void set_regs(logic [7:0] sw, logic [7:0] lw, logic [3:0] nl);
			short_wait = sw;
			long_wait = lw;
			fresh_len_cfg = nl;
		endfunction

		function void push_entry(logic [3:0] d);
			if (entry_len < DIGITS) begin
				entry_q[entry_len] = d;
				entry_len = entry_len + 4'd1;
			end
		endfunction

		function void push_fresh(logic [3:0] d);
			if (fresh_len < DIGITS) begin
				fresh_q[fresh_len] = d;
				fresh_len = fresh_len + 4'd1;
			end
		endfunction

		function bit entry_hit();
			if (entry_len != code_len)
				return 0;
			for (int i = 0; i < DIGITS; i++)
				if (i < code_len && entry_q[i] != code_q[i])
					return 0;
			return 1;
		endfunction

		function void commit_if_full();
			if (fresh_len == fresh_len_cfg) begin
				code_q = fresh_q;
				code_len = fresh_len;
				fresh_len = 4'd0;
				entry_len = 4'd0;
				verified = 0;
				change_mode = CHG_NONE;
				r.status_code = ST_STORED;
			end else begin
				r.status_code = ST_DIGIT;
			end
		endfunction

		function void judge_entry();
			logic [2:0] a;
			a = attempt;
			r.status_code = ST_DIGIT;
			if (a < 3'd1 || a > 3'd5 || entry_len != code_len)
				return;
			if (entry_hit()) begin
				entry_len = 4'd0;
				door_open = 1;
				presence_served = 0;
				attempt = 3'd1;
				r.motor_cmd = MOTOR_UNLOCK;
				r.log_pulse = LOG_CODE;
				r.status_code = ST_GRANTED;
				return;
			end
			entry_len = 4'd0;
			attempt = a + 3'd1;
			case (a)
				3'd3: begin
					wait_left = short_wait;
					r.status_code = ST_WAIT;
				end
				3'd4: begin
					wait_left = long_wait;
					r.status_code = ST_WAIT;
				end
				3'd5: begin
					lock_mode = LOCK_HARD;
					r.status_code = ST_HARD;
				end
				default: r.status_code = ST_WRONG;
			endcase
		endfunction

		function void take_digit(logic [3:0] d);
			if (lock_mode != LOCK_NONE) begin
				r.status_code = ST_IGNORED;
			end else if (!door_open && change_mode == CHG_NONE) begin
				push_entry(d);
				judge_entry();
			end else if (change_mode == CHG_ACTIVE) begin
				push_entry(d);
				if (!verified) begin
					r.status_code = ST_DIGIT;
					if (entry_len == code_len) begin
						if (entry_hit()) begin
							verified = 1;
							r.status_code = ST_VERIFIED;
						end else begin
							change_mode = CHG_NONE;
							r.status_code = ST_WRONG;
						end
						entry_len = 4'd0;
					end
				end else begin
					push_fresh(d);
					commit_if_full();
				end
			end else if (change_mode == CHG_FORCED) begin
				push_fresh(d);
				commit_if_full();
			end else begin
				r.status_code = ST_IGNORED;
			end
		endfunction

		function out_item_t note_event(in_item_t it);
			r = '0;
			if (it.req_type == REQ_TICK) begin
				if (wait_left != 0) begin
					wait_left = wait_left - 8'd1;
					r.status_code = ST_WAIT;
				end
			end else if (wait_left != 0) begin
				r.status_code = ST_IGNORED;
			end else begin
				r.status_code = ST_IGNORED;
				case (it.req_type)
					REQ_DIGIT: take_digit(it.digit);
					REQ_STAR: begin
						if (lock_mode == LOCK_NONE && door_open) begin
							door_open = 0;
							presence_served = 0;
							r.motor_cmd = MOTOR_LOCK;
							r.status_code = ST_LOCKED;
						end
					end
					REQ_HASH: begin
						if (!door_open && !verified && change_mode == CHG_NONE &&
								lock_mode == LOCK_NONE) begin
							entry_len = 4'd0;
							r.status_code = ST_CLEARED;
						end else if (change_mode == CHG_ACTIVE && !verified) begin
							entry_len = 4'd0;
							r.status_code = ST_CLEARED;
						end else if (change_mode == CHG_ACTIVE || change_mode == CHG_FORCED) begin
							fresh_len = 4'd0;
							r.status_code = ST_CLEARED;
						end
					end
					REQ_KEY_A: begin
						if (lock_mode == LOCK_NONE) begin
							entry_len = 4'd0;
							fresh_len = 4'd0;
							change_mode = CHG_ACTIVE;
							r.status_code = ST_CHANGE;
						end
					end
					REQ_KEY_B: begin
						if (lock_mode == LOCK_HARD) begin
							reset_asked = 1;
							r.status_code = ST_RESET;
						end
					end
					REQ_KEY_C: begin
						if (lock_mode == LOCK_NONE && !answer_asked) begin
							answer_asked = 1;
							r.status_code = ST_PHONE;
						end else if (lock_mode == LOCK_HARD && reset_asked) begin
							phone_mode = PHONE_RESET;
							r.phone_pulse = 1'b1;
							r.status_code = ST_PHONE;
						end
					end
					REQ_KEY_D: begin
						if (answer_asked) begin
							lock_mode = LOCK_ANSWER;
							phone_mode = PHONE_ANSWER;
							r.phone_pulse = 1'b1;
							r.status_code = ST_PHONE;
						end
					end
					REQ_PH_RESET: begin
						if (lock_mode == LOCK_HARD && reset_asked && phone_mode == PHONE_RESET) begin
							lock_mode = LOCK_NONE;
							reset_asked = 0;
							phone_mode = PHONE_IDLE;
							attempt = 3'd1;
							change_mode = CHG_FORCED;
							r.status_code = ST_UNLOCKED;
						end
					end
					REQ_PH_ANS: begin
						if (lock_mode == LOCK_ANSWER && answer_asked &&
								phone_mode == PHONE_ANSWER) begin
							answer_asked = 0;
							lock_mode = LOCK_NONE;
							phone_mode = PHONE_IDLE;
							r.status_code = ST_ANSWER;
						end
					end
					REQ_IDLE: begin
						if (!presence_served && !door_open) begin
							presence_served = 1;
							door_open = 1;
							attempt = 3'd1;
							lock_mode = LOCK_NONE;
							reset_asked = 0;
							phone_mode = PHONE_IDLE;
							answer_asked = 0;
							r.motor_cmd = MOTOR_UNLOCK;
							r.log_pulse = LOG_PRESENCE;
							r.status_code = ST_GRANTED;
						end else if (door_open) begin
							presence_served = 0;
							door_open = 0;
							attempt = 3'd1;
							phone_mode = PHONE_IDLE;
							r.motor_cmd = MOTOR_LOCK;
							r.status_code = ST_LOCKED;
						end
					end
					default: ;
				endcase
			end
			r.waiting = (wait_left != 0);
			due.push_back(r);
			return r;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_MAX)
					$display("%t: result %h arrived with nothing outstanding", $time, got);
				return;
			end
			want = due.pop_front();
			if (got.motor_cmd !== want.motor_cmd || got.status_code !== want.status_code ||
					got.phone_pulse !== want.phone_pulse || got.log_pulse !== want.log_pulse ||
					got.waiting !== want.waiting) begin
				bad_results++;
				if (bad_results <= REPORT_MAX)
					$display("%t: expected motor %0d status %0d phone %0d log %0d waiting %0d, got motor %0d status %0d phone %0d log %0d waiting %0d",
						$time, want.motor_cmd, want.status_code, want.phone_pulse,
						want.log_pulse, want.waiting, got.motor_cmd, got.status_code,
						got.phone_pulse, got.log_pulse, got.waiting);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	in_item_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;

	code_lock_mirror mirror;
	int live_items = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	bit tx_idle_on = 1;
	bit rx_idle_on = 1;

	always #6 clk = ~clk;

	keypad_code_lock_controller dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.res_valid,
		.res_stall,
		.res,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	task automatic offer_event(input logic [3:0] kind, input logic [3:0] d);
		in_item_t it;
		out_item_t predicted;
		int unsigned gap;
		it.req_type = kind;
		it.digit = d;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = mirror.note_event(it);
		if (predicted.status_code != ST_IGNORED)
			live_items++;
	endtask

	task automatic press(input req_t k);
		offer_event(k, 4'($urandom_range(0, 15)));
	endtask

	task automatic enter_code(input bit right, input int extra);
		logic [3:0] want [DIGITS];
		int n;
		want = mirror.code_q;
		n = mirror.code_len;
		if (mirror.door_open && mirror.change_mode == CHG_NONE)
			press(REQ_STAR);
		if ($urandom_range(0, 9) < 8)
			press(REQ_HASH);
		for (int i = 0; i < n + extra; i++)
			offer_event(REQ_DIGIT, (right && i < n) ? want[i] : 4'($urandom_range(0, 9)));
	endtask

	task automatic enter_fresh();
		int n;
		n = mirror.fresh_len_cfg;
		if (n == 0 || n > DIGITS)
			n = DIGITS + 1;
		if ($urandom_range(0, 1) == 0)
			press(REQ_HASH);
		for (int i = 0; i < n; i++)
			offer_event(REQ_DIGIT, ($urandom_range(0, 19) < 19) ?
				4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15)));
	endtask

	task automatic run_sequence();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			tx_idle_on = !tx_idle_on;
		if ($urandom_range(0, 19) == 0)
			rx_idle_on = !rx_idle_on;
		if (mirror.wait_left != 0) begin
			if (pick < 85)
				press(REQ_TICK);
			else
				offer_event(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		end else if (mirror.lock_mode == LOCK_HARD && pick < 75) begin
			if (pick < 20 && mirror.answer_asked) begin
				press(REQ_KEY_D);
				press(REQ_PH_ANS);
				enter_code(0, 3);
			end else begin
				press(REQ_KEY_B);
				press(REQ_KEY_C);
				press(REQ_PH_RESET);
				if (mirror.change_mode == CHG_FORCED)
					enter_fresh();
			end
		end else if (mirror.lock_mode == LOCK_ANSWER && pick < 70) begin
			press(REQ_PH_ANS);
		end else if (mirror.change_mode == CHG_FORCED && pick < 70) begin
			enter_fresh();
		end else if (mirror.change_mode == CHG_ACTIVE && pick < 60) begin
			if (mirror.verified)
				enter_fresh();
			else
				enter_code(pick < 50, 0);
		end else if (pick < 35) begin
			enter_code($urandom_range(0, 9) < 4, ($urandom_range(0, 9) == 0) ? 2 : 0);
		end else if (pick < 43) begin
			repeat ($urandom_range(3, 5)) begin
				while (mirror.wait_left != 0)
					press(REQ_TICK);
				enter_code(0, 0);
			end
		end else if (pick < 53) begin
			press(REQ_KEY_A);
			enter_code($urandom_range(0, 9) < 8, 0);
			if (mirror.change_mode == CHG_ACTIVE && mirror.verified)
				enter_fresh();
		end else if (pick < 60) begin
			press(($urandom_range(0, 1) == 0) ? REQ_IDLE : REQ_STAR);
		end else if (pick < 66) begin
			press(REQ_KEY_C);
			press(REQ_KEY_D);
			press(REQ_PH_ANS);
		end else if (pick < 72) begin
			repeat ($urandom_range(1, 4)) press(REQ_TICK);
		end else begin
			repeat ($urandom_range(1, 4))
				offer_event(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (mirror.due.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] sw, input logic [7:0] lw, input logic [3:0] nl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHORT_WAIT;
		cfg_data <= sw;
		@(posedge clk);
		cfg_index <= CFG_LONG_WAIT;
		cfg_data <= lw;
		@(posedge clk);
		cfg_index <= CFG_NEW_LEN;
		cfg_data <= {4'($urandom_range(0, 15)), nl};
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_regs(sw, lw, nl);
	endtask

	task automatic exercise(input logic [7:0] sw, input logic [7:0] lw, input logic [3:0] nl,
			input int goal);
		int start;
		settle();
		configure(sw, lw, nl);
		start = live_items;
		while (live_items - start < goal)
			run_sequence();
	endtask

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("keypad_code_lock_controller: mismatch");
			$finish;
		end
	end

	initial begin : result_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				mirror.check_result(res);
				results_seen++;
				hold = rx_idle_on ? $urandom_range(0, 7) : 0;
				// hold off long enough for both item registers to fill
				if (results_seen % 700 == 350)
					hold = 48;
				if (hold != 0) begin
					res_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					res_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		int start;
		mirror = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		press(REQ_TICK);
		press(REQ_STAR);
		press(REQ_IDLE);
		press(REQ_IDLE);
		for (int i = 1; i <= 6; i++)
			offer_event(REQ_DIGIT, 4'(i));
		press(REQ_STAR);
		offer_event(REQ_SPARE_LO, 4'($urandom_range(0, 15)));
		offer_event(REQ_SPARE_HI, 4'($urandom_range(0, 15)));
		offer_event(REQ_DIGIT, 4'd15);
		press(REQ_HASH);
		offer_event(REQ_DIGIT, 4'd0);
		offer_event(REQ_DIGIT, 4'd9);
		press(REQ_HASH);
		press(REQ_KEY_B);
		press(REQ_KEY_C);
		press(REQ_KEY_D);
		offer_event(REQ_DIGIT, 4'd5);
		press(REQ_PH_ANS);
		press(REQ_PH_RESET);
		press(REQ_KEY_A);
		press(REQ_HASH);

		start = live_items;
		while (live_items - start < 250)
			run_sequence();
		exercise(8'd0, 8'd255, 4'd9, 300);
		exercise(8'd255, 8'd0, 4'd1, 250);
		exercise(8'd3, 8'd5, 4'd0, 150);
		exercise(8'd1, 8'd2, 4'd15, 150);
		exercise(8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
			4'($urandom_range(1, 9)), 450);

		settle();
		repeat (8) @(posedge clk);
		if (mirror.bad_results == 0 && mirror.due.size() == 0)
			$display("keypad_code_lock_controller: match");
		else
			$display("keypad_code_lock_controller: mismatch");
		$finish;
	end

endmodule
